[rtl/ctt_pkg.sv]
// shared widths, token codes and the result item type of the config text tokenizer
package ctt_pkg;

    localparam int POS_W       = 32;
    localparam int LEN_W       = 16;
    localparam int LINE_W      = 20;
    localparam int DEPTH_W     = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_WORD   = 3'd0,
        KIND_SEMI   = 3'd1,
        KIND_BSTART = 3'd2,
        KIND_BEND   = 3'd3,
        KIND_ERROR  = 3'd4,
        KIND_END    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_IDLE  = 3'd1,
        ERR_BAD_WORD  = 3'd2,
        ERR_OPEN_QUOT = 3'd3,
        ERR_UNMATCHED = 3'd4,
        ERR_NO_SEMI   = 3'd5,
        ERR_NEST      = 3'd6
    } err_t;

    typedef struct packed {
        kind_t              kind;
        err_t               err;
        logic [POS_W-1:0]   offset;
        logic [LEN_W-1:0]   length;
        logic [LINE_W-1:0]  line;
        logic               last;
    } result_t;

endpackage

[rtl/ctt_lexer.sv]
// lexer state and the per-byte token decision, up to two result items per input item
module ctt_lexer
    import ctt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        end_marker,
    output result_t     res0,
    output result_t     res1,
    output logic [1:0]  nres
);

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_COMMENT  = 3'd1,
        ST_WORD     = 3'd2,
        ST_QUOTED   = 3'd3,
        ST_WCOMMENT = 3'd4,
        ST_HALT     = 3'd5
    } scan_t;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c == 8'h2F ||
               c == 8'h2E || c == 8'h3A || c == 8'h3D || c == 8'h2D;
    endfunction

    scan_t               state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    start_reg, start_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic                pend_reg, pend_next;

    logic [LINE_W-1:0]   line_up;
    logic [LEN_W-1:0]    count_up;
    logic                is_ws, is_delim;
    result_t             word_res, plain_res, delim_res, r0, r1;
    logic [DEPTH_W-1:0]  delim_depth;
    logic                delim_halt;
    logic [1:0]          n;

    assign line_up  = (line_reg == '1) ? line_reg : line_reg + LINE_W'(1);
    assign count_up = (count_reg == '1) ? count_reg : count_reg + LEN_W'(1);
    assign is_ws    = data_byte == CH_SPACE || data_byte == CH_TAB || data_byte == CH_NL;
    assign is_delim = data_byte == CH_SEMI || data_byte == CH_LBRACE ||
                      data_byte == CH_RBRACE;

    // delimiter token, independent of scan state
    always_comb
    begin
        plain_res   = '{kind: KIND_END, err: ERR_NONE, offset: '0, length: '0,
                        line: line_reg, last: 1'b0};
        word_res    = '{kind: KIND_WORD, err: ERR_NONE, offset: start_reg,
                        length: count_reg, line: line_reg, last: 1'b0};
        delim_res   = plain_res;
        delim_depth = depth_reg;
        delim_halt  = 1'b0;
        priority if (data_byte == CH_SEMI)
        begin
            delim_res.kind = KIND_SEMI;
        end
        else if (data_byte == CH_LBRACE)
        begin
            if (depth_reg == '1)
            begin
                delim_res.kind = KIND_ERROR;
                delim_res.err  = ERR_NEST;
                delim_halt     = 1'b1;
            end
            else
            begin
                delim_res.kind = KIND_BSTART;
                delim_depth    = depth_reg + DEPTH_W'(1);
            end
        end
        else
        begin
            if (depth_reg == '0)
            begin
                delim_res.kind = KIND_ERROR;
                delim_res.err  = ERR_UNMATCHED;
                delim_halt     = 1'b1;
            end
            else
            begin
                delim_res.kind = KIND_BEND;
                delim_depth    = depth_reg - DEPTH_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg + POS_W'(1);
        start_next = start_reg;
        count_next = count_reg;
        line_next  = line_reg;
        depth_next = depth_reg;
        pend_next  = pend_reg;
        r0         = plain_res;
        r1         = plain_res;
        n          = 2'd0;
        if (end_marker)
        begin
            state_next = ST_IDLE;
            pos_next   = '0;
            start_next = '0;
            count_next = '0;
            line_next  = LINE_W'(1);
            depth_next = '0;
            pend_next  = 1'b0;
            if (state_reg == ST_WORD)
            begin
                // the flushed word leaves words pending, so the missing semicolon follows
                r0      = word_res;
                r1.kind = KIND_ERROR;
                r1.err  = ERR_NO_SEMI;
                n       = 2'd2;
            end
            else
            begin
                n = 2'd1;
                priority if (state_reg == ST_HALT)
                begin
                    r0.kind = KIND_END;
                end
                else if (state_reg == ST_QUOTED)
                begin
                    r0.kind = KIND_ERROR;
                    r0.err  = ERR_OPEN_QUOT;
                end
                else if (pend_reg)
                begin
                    r0.kind = KIND_ERROR;
                    r0.err  = ERR_NO_SEMI;
                end
                else
                begin
                    r0.kind = KIND_END;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    priority if (data_byte == CH_HASH)
                    begin
                        state_next = ST_COMMENT;
                    end
                    else if (is_ws)
                    begin
                        if (data_byte == CH_NL)
                            line_next = line_up;
                    end
                    else if (is_delim)
                    begin
                        r0         = delim_res;
                        n          = 2'd1;
                        pend_next  = 1'b0;
                        depth_next = delim_depth;
                        if (delim_halt)
                            state_next = ST_HALT;
                    end
                    else if (is_letter(data_byte))
                    begin
                        start_next = pos_reg;
                        count_next = LEN_W'(1);
                        state_next = ST_WORD;
                    end
                    else if (data_byte == CH_QUOTE)
                    begin
                        start_next = pos_reg + POS_W'(1);
                        count_next = '0;
                        state_next = ST_QUOTED;
                    end
                    else
                    begin
                        r0.kind    = KIND_ERROR;
                        r0.err     = ERR_BAD_IDLE;
                        n          = 2'd1;
                        state_next = ST_HALT;
                    end
                end
                ST_COMMENT, ST_WCOMMENT:
                begin
                    if (data_byte == CH_NL)
                    begin
                        line_next  = line_up;
                        state_next = ST_IDLE;
                    end
                end
                ST_WORD:
                begin
                    priority if (is_letter(data_byte))
                    begin
                        count_next = count_up;
                    end
                    else if (is_ws)
                    begin
                        r0         = word_res;
                        n          = 2'd1;
                        pend_next  = 1'b1;
                        state_next = ST_IDLE;
                        if (data_byte == CH_NL)
                            line_next = line_up;
                    end
                    else if (is_delim)
                    begin
                        r0         = word_res;
                        r1         = delim_res;
                        n          = 2'd2;
                        pend_next  = 1'b0;
                        depth_next = delim_depth;
                        state_next = delim_halt ? ST_HALT : ST_IDLE;
                    end
                    else if (data_byte == CH_HASH)
                    begin
                        r0         = word_res;
                        n          = 2'd1;
                        pend_next  = 1'b1;
                        state_next = ST_WCOMMENT;
                    end
                    else
                    begin
                        r0.kind    = KIND_ERROR;
                        r0.err     = ERR_BAD_WORD;
                        n          = 2'd1;
                        state_next = ST_HALT;
                    end
                end
                ST_QUOTED:
                begin
                    if (data_byte == CH_QUOTE)
                    begin
                        r0         = word_res;
                        n          = 2'd1;
                        pend_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (data_byte == CH_NL)
                            line_next = line_up;
                        count_next = count_up;
                    end
                end
                ST_HALT:
                begin
                    state_next = ST_HALT;
                end
                default:
                begin
                    state_next = ST_HALT;
                end
            endcase
        end
        if (n == 2'd2)
            r1.last = 1'b1;
        else
            r0.last = 1'b1;
    end

    assign res0 = r0;
    assign res1 = r1;
    assign nres = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            count_reg <= '0;
            line_reg  <= LINE_W'(1);
            depth_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            count_reg <= count_next;
            line_reg  <= line_next;
            depth_reg <= depth_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

[rtl/config_text_tokenizer.sv]
// top level of the config text tokenizer: lexer plus result item queue
// The tokenizer takes one text byte (or the end marker) per cycle while
// in_ready is high and is decided in the same cycle it is accepted; its result
// items go into a four-entry queue that drains one item per cycle while
// out_ready is high. A byte that ends a word at ';', '{' or '}', and an end
// marker that closes a bare word, give two result items, so such an input item
// fills two queue entries; all others fill one or none. in_ready is high while
// the queue has at least two free entries, so with the output side always ready
// the block sustains one input item per cycle, but two-result items can hold the
// input side. Result items are registered in the queue before they reach the output.
module config_text_tokenizer
    import ctt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_marker,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         token_kind,
    output logic [2:0]         error_code,
    output logic [POS_W-1:0]   word_offset,
    output logic [LEN_W-1:0]   word_length,
    output logic [LINE_W-1:0]  line_number,
    output logic               last
);

    result_t             res0, res1, head;
    logic [1:0]          nres, push;
    logic                accept, pop;
    result_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign in_ready  = cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign accept    = in_valid && in_ready;
    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && out_ready;
    assign push      = accept ? nres : 2'd0;

    ctt_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .end_marker (end_marker),
        .res0       (res0),
        .res1       (res1),
        .nres       (nres)
    );

    always_ff @(posedge clk)
    begin
        if (push != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (push == 2'd2)
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign head        = queue_reg[rd_ptr_reg];
    assign token_kind  = head.kind;
    assign error_code  = head.err;
    assign word_offset = head.offset;
    assign word_length = head.length;
    assign line_number = head.line;
    assign last        = head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != KIND_ERROR |-> error_code == ERR_NONE)
        else $error("error code on a non-error item");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_END |-> last)
        else $error("end of input item not marked last");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_marker |=> out_valid)
        else $error("end marker produced no result item");

endmodule

[test/tb.sv]
// self-checking testbench for the config text tokenizer: predicted tokens vs. the block's output
module tb;
    import ctt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int LONG_HOLD    = 250;
    localparam int TAIL_CYCLES  = 12;
    localparam int RANDOM_ITEMS = 750;
    localparam int MAX_REPORTS  = 50;

    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_OPEN  = "{";
    localparam logic [7:0] CH_CLOSE = "}";
    localparam logic [7:0] CH_QUOTE = "\"";
    localparam logic [7:0] CH_TAB   = "\t";
    localparam logic [7:0] CH_NL    = "\n";
    localparam logic [7:0] CH_SPACE = " ";

    typedef enum logic [2:0] {
        SC_IDLE, SC_COMMENT, SC_WORD, SC_QUOTED, SC_WCOMMENT, SC_HALT
    } scan_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        data_byte = 8'h00;
    logic              end_marker = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        token_kind;
    logic [2:0]        error_code;
    logic [POS_W-1:0]  word_offset;
    logic [LEN_W-1:0]  word_length;
    logic [LINE_W-1:0] line_number;
    logic              last;

    config_text_tokenizer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .end_marker (end_marker),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .token_kind (token_kind),
        .error_code (error_code),
        .word_offset(word_offset),
        .word_length(word_length),
        .line_number(line_number),
        .last       (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // lexer state as the block should hold it
    scan_t              lx_scan;
    logic [POS_W-1:0]   lx_pos;
    logic [POS_W-1:0]   lx_start;
    logic [LEN_W-1:0]   lx_len;
    logic [LINE_W-1:0]  lx_line;
    logic [DEPTH_W-1:0] lx_depth;
    logic               lx_words_open;

    result_t step_out[$];
    result_t tokens_due[$];

    int errors = 0;
    int tokens_seen = 0;
    int bytes_offered = 0;
    int texts_done = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;

    function automatic bit is_word_char(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "_" || c == "/" || c == "." ||
               c == ":" || c == "=" || c == "-";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL;
    endfunction

    function automatic bit is_delim(logic [7:0] c);
        return c == CH_SEMI || c == CH_OPEN || c == CH_CLOSE;
    endfunction

    // mostly no gap, some short gaps, a few long ones
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic lex_reset();
        lx_scan       = SC_IDLE;
        lx_pos        = '0;
        lx_start      = '0;
        lx_len        = '0;
        lx_line       = LINE_W'(1);
        lx_depth      = '0;
        lx_words_open = 1'b0;
    endtask

    task automatic line_up();
        if (lx_line != '1)
            lx_line = lx_line + 1'b1;
    endtask

    task automatic count_up();
        if (lx_len != '1)
            lx_len = lx_len + 1'b1;
    endtask

    task automatic put_token(kind_t k, err_t e, logic [POS_W-1:0] off, logic [LEN_W-1:0] len);
        result_t t;
        t.kind   = k;
        t.err    = e;
        t.offset = off;
        t.length = len;
        t.line   = lx_line;
        t.last   = 1'b0;
        step_out.push_back(t);
    endtask

    task automatic put_word();
        put_token(KIND_WORD, ERR_NONE, lx_start, lx_len);
        lx_words_open = 1'b1;
    endtask

    task automatic put_error(err_t e);
        put_token(KIND_ERROR, e, '0, '0);
        lx_scan = SC_HALT;
    endtask

    task automatic put_delim(logic [7:0] c);
        lx_words_open = 1'b0;
        if (c == CH_SEMI)
            put_token(KIND_SEMI, ERR_NONE, '0, '0);
        else if (c == CH_OPEN)
        begin
            if (lx_depth == '1)
                put_error(ERR_NEST);
            else
            begin
                lx_depth = lx_depth + 1'b1;
                put_token(KIND_BSTART, ERR_NONE, '0, '0);
            end
        end
        else if (lx_depth == '0)
            put_error(ERR_UNMATCHED);
        else
        begin
            lx_depth = lx_depth - 1'b1;
            put_token(KIND_BEND, ERR_NONE, '0, '0);
        end
    endtask

    // tokens caused by one accepted item, appended to tokens_due
    task automatic lex_step(logic [7:0] c, logic em);
        result_t t;
        step_out.delete();
        if (em)
        begin
            if (lx_scan == SC_WORD)
                put_word();
            if (lx_scan == SC_HALT)
                put_token(KIND_END, ERR_NONE, '0, '0);
            else if (lx_scan == SC_QUOTED)
                put_token(KIND_ERROR, ERR_OPEN_QUOT, '0, '0);
            else if (lx_words_open)
                put_token(KIND_ERROR, ERR_NO_SEMI, '0, '0);
            else
                put_token(KIND_END, ERR_NONE, '0, '0);
            lex_reset();
        end
        else
        begin
            unique case (lx_scan)
                SC_IDLE:
                begin
                    if (c == CH_HASH)
                        lx_scan = SC_COMMENT;
                    else if (is_blank(c))
                    begin
                        if (c == CH_NL)
                            line_up();
                    end
                    else if (is_delim(c))
                        put_delim(c);
                    else if (is_word_char(c))
                    begin
                        lx_start = lx_pos;
                        lx_len   = LEN_W'(1);
                        lx_scan  = SC_WORD;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        lx_start = lx_pos + 1'b1;
                        lx_len   = '0;
                        lx_scan  = SC_QUOTED;
                    end
                    else
                        put_error(ERR_BAD_IDLE);
                end
                SC_COMMENT, SC_WCOMMENT:
                begin
                    if (c == CH_NL)
                    begin
                        line_up();
                        lx_scan = SC_IDLE;
                    end
                end
                SC_WORD:
                begin
                    if (is_word_char(c))
                        count_up();
                    else if (is_blank(c))
                    begin
                        // the word carries the line before the newline
                        put_word();
                        lx_scan = SC_IDLE;
                        if (c == CH_NL)
                            line_up();
                    end
                    else if (is_delim(c))
                    begin
                        put_word();
                        lx_scan = SC_IDLE;
                        put_delim(c);
                    end
                    else if (c == CH_HASH)
                    begin
                        put_word();
                        lx_scan = SC_WCOMMENT;
                    end
                    else
                        put_error(ERR_BAD_WORD);
                end
                SC_QUOTED:
                begin
                    if (c == CH_QUOTE)
                    begin
                        put_word();
                        lx_scan = SC_IDLE;
                    end
                    else
                    begin
                        if (c == CH_NL)
                            line_up();
                        count_up();
                    end
                end
                default: ;
            endcase
            lx_pos = lx_pos + 1'b1;
        end
        if (step_out.size() > 0)
        begin
            t = step_out.pop_back();
            t.last = 1'b1;
            step_out.push_back(t);
        end
        while (step_out.size() > 0)
            tokens_due.push_back(step_out.pop_front());
    endtask

    // valid stays high after acceptance; it drops only in a gap or a drain
    task automatic offer_byte(logic [7:0] b, logic em);
        int gap;
        gap = pick_gap(sender_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        end_marker <= em;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lex_step(b, em);
        bytes_offered++;
    endtask

    task automatic offer_text(string s);
        for (int i = 0; i < s.len(); i++)
            offer_byte(s[i], 1'b0);
    endtask

    task automatic offer_end();
        offer_byte(8'($urandom_range(0, 255)), 1'b1);
        texts_done++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        case ($urandom_range(0, 3))
            0: return "A" + 8'($urandom_range(0, 25));
            1: return "a" + 8'($urandom_range(0, 25));
            2: return "0" + 8'($urandom_range(0, 9));
            default:
                case ($urandom_range(0, 5))
                    0: return "_";
                    1: return "/";
                    2: return ".";
                    3: return ":";
                    4: return "=";
                    default: return "-";
                endcase
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0: return CH_TAB;
            1: return CH_NL;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic offer_word();
        int n;
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(0, 5);
            offer_byte(CH_QUOTE, 1'b0);
            repeat (n)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_QUOTE || $urandom_range(0, 4) == 0)
                    c = CH_NL;
                offer_byte(c, 1'b0);
            end
            offer_byte(CH_QUOTE, 1'b0);
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                offer_byte(rand_letter(), 1'b0);
        end
    endtask

    task automatic offer_comment();
        int n;
        logic [7:0] c;
        n = $urandom_range(0, 6);
        offer_byte(CH_HASH, 1'b0);
        repeat (n)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_NL)
                c = CH_SPACE;
            offer_byte(c, 1'b0);
        end
        offer_byte(CH_NL, 1'b0);
    endtask

    task automatic offer_statement(inout int depth);
        int n;
        int r;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 || $urandom_range(0, 1) == 1)
                offer_byte(rand_blank(), 1'b0);
            offer_word();
        end
        if ($urandom_range(0, 1) == 1)
            offer_byte(rand_blank(), 1'b0);
        r = $urandom_range(0, 9);
        if (r < 6)
            offer_byte(CH_SEMI, 1'b0);
        else if (r < 8 && depth < 4)
        begin
            offer_byte(CH_OPEN, 1'b0);
            depth++;
        end
        else if (r < 9)
            offer_comment();
    endtask

    task automatic random_text();
        int depth;
        int steps;
        int r;
        case ($urandom_range(0, 3))
            0: begin sender_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin sender_idle_pct = 30; recv_idle_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_idle_pct = 30; end
            default: begin sender_idle_pct = 30; recv_idle_pct = 30; end
        endcase
        depth = 0;
        steps = $urandom_range(2, 10);
        repeat (steps)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                offer_statement(depth);
            else if (r < 65)
            begin
                // a close at depth zero is a broken sequence on purpose
                if (depth > 0 || $urandom_range(0, 7) == 0)
                begin
                    offer_byte(CH_CLOSE, 1'b0);
                    if (depth > 0)
                        depth--;
                end
            end
            else if (r < 75)
                offer_comment();
            else if (r < 90)
                offer_byte(rand_blank(), 1'b0);
            else if (r < 95)
                offer_byte(8'($urandom_range(0, 255)), 1'b0);
            else
                offer_word();
        end
        if ($urandom_range(0, 9) < 7)
            while (depth > 0)
            begin
                offer_byte(CH_CLOSE, 1'b0);
                depth--;
            end
        offer_end();
    endtask

    task automatic test_directed();
        sender_idle_pct = 20;
        recv_idle_pct   = 20;
        // tab, plain comment, word before semicolon, block around a word, newline after a
        // word, quoted newline, comment after a word, then end with a word pending
        offer_text("\t#\na;{b}c\n\"\n\"d#\n");
        offer_end();
        // unmatched close, then an ignored byte while halted
        offer_text("}");
        offer_byte(8'hFF, 1'b0);
        offer_end();
        offer_text("e");
        offer_end();
        offer_text("\"");
        offer_end();
        offer_byte(8'h00, 1'b0);
        offer_end();
        offer_text("f");
        offer_byte(8'hFF, 1'b0);
        offer_end();
        wait_drained();
    endtask

    task automatic test_nesting_limit();
        sender_idle_pct = 10;
        recv_idle_pct   = 10;
        repeat ((1 << DEPTH_W) - 1)
            offer_byte(CH_OPEN, 1'b0);
        offer_byte(CH_OPEN, 1'b0);
        offer_end();
        // open blocks at the end are not an error
        offer_text("{x;");
        offer_end();
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        hold_requests++;
        repeat (6)
            offer_text("key val;");
        offer_end();
        wait_drained();
    endtask

    task automatic test_random_texts();
        int first;
        first = bytes_offered;
        while (bytes_offered - first < RANDOM_ITEMS)
        begin
            random_text();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // output side: ready pattern and token comparison
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind   = kind_t'(token_kind);
            got.err    = err_t'(error_code);
            got.offset = word_offset;
            got.length = word_length;
            got.line   = line_number;
            got.last   = last;
            tokens_seen++;
            if (tokens_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t tb: unexpected token kind %0d err %0d line %0d", $time,
                             got.kind, got.err, got.line);
            end
            else
            begin
                want = tokens_due.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"%0t tb: token mismatch, expected kind %0d err %0d ",
                                  "off %0d len %0d line %0d last %0d, got kind %0d err %0d ",
                                  "off %0d len %0d line %0d last %0d"}, $time,
                                 want.kind, want.err, want.offset, want.length, want.line,
                                 want.last, got.kind, got.err, got.offset, got.length,
                                 got.line, got.last);
                end
            end
        end
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap(recv_idle_pct);
            out_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles, %0d tokens still due", cycle_count,
                     tokens_due.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        lex_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_nesting_limit();
        test_output_backpressure();
        test_random_texts();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("tb: %0d bytes and end markers over %0d texts, %0d tokens compared",
                 bytes_offered, texts_done, tokens_seen);
        $display("tb: covered errors, nesting limit, random texts and output stalls");
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
